// ===== rtl/nearest_neighbor_tour_defines.svh =====
// Assertion macros shared by the nearest-neighbor tour checkers
`ifndef NEAREST_NEIGHBOR_TOUR_DEFINES_SVH
`define NEAREST_NEIGHBOR_TOUR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define NNT_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("nearest_neighbor_tour: check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define NNT_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("nearest_neighbor_tour: check failed");

`endif

// ===== rtl/nnt_pkg.sv =====
// Types and constants shared by the nearest-neighbor tour modules
package nnt_pkg;

    // Fixed field widths
    localparam int ROW_W  = 5;
    localparam int REQ_W  = 16;
    localparam int NODE_W_OUT = 5;
    localparam int LEN_W  = 22;
    localparam int CNT_W  = 6;

    localparam logic [LEN_W-1:0] LEN_MAX        = 22'h3FFFFF;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;
    localparam logic [CNT_W-1:0] NODE_COUNT_MIN = 6'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_SCAN_END,
        ST_STEP,
        ST_CLOSE,
        ST_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             mem_wr;
        logic             rd_scan;
        logic             rd_close;
        logic             tour_init;
        logic             step;
        logic             emit_last;
        logic [CNT_W-1:0] col;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [CNT_W-1:0] n_eff;
        logic             out_free;
    } status_t;

endpackage

// ===== rtl/nnt_ctrl.sv =====
// Tour controller: load, per-step row scan, closing edge, result sequencing
module nnt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            last,
    input  nnt_pkg::status_t status,
    output nnt_pkg::cmd_t    cmd
);
    import nnt_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] n_last;

    assign n_last = status.n_eff - CNT_W'(1);

    // State and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.col    = col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.mem_wr = 1'b1;
                    if (last)
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                // node 0 opens the tour
                if (status.out_free)
                begin
                    cmd.tour_init = 1'b1;
                    col_next      = '0;
                    step_next     = CNT_W'(1);
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one read of the current row per cycle
                cmd.rd_scan = 1'b1;
                if (col_reg == n_last)
                    state_next = ST_SCAN_END;
                else
                    col_next = col_reg + CNT_W'(1);
            end
            ST_SCAN_END:
            begin
                // last column compared this cycle
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.out_free)
                begin
                    cmd.step = 1'b1;
                    col_next = '0;
                    if (step_reg == n_last)
                        state_next = ST_CLOSE;
                    else
                    begin
                        step_next  = step_reg + CNT_W'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CLOSE:
            begin
                // fetch return edge from row 0
                cmd.rd_close = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/nnt_datapath.sv =====
// Tour datapath: distance memory, min search, length sum, output register
module nnt_datapath #(
    parameter int MAX_NODES = 32,
    parameter int DIST_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [nnt_pkg::CNT_W-1:0]    node_count,
    input  logic [nnt_pkg::ROW_W-1:0]    row,
    input  logic [nnt_pkg::ROW_W-1:0]    col,
    input  logic [nnt_pkg::REQ_W-1:0]    dist_req,
    input  nnt_pkg::cmd_t                cmd,
    output nnt_pkg::status_t             status,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [nnt_pkg::NODE_W_OUT-1:0] node,
    output logic [nnt_pkg::LEN_W-1:0]    tour_length,
    output logic                         is_last
);
    import nnt_pkg::*;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DEPTH  = MAX_NODES * MAX_NODES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = ((DIST_BITS > LEN_W) ? DIST_BITS : LEN_W) + 1;

    // Distance memory
    logic [DIST_BITS-1:0] mem [DEPTH];
    logic [DIST_BITS-1:0] rd_data_reg;

    logic [CNT_W-1:0]     ncount_reg;
    logic [MAX_NODES-1:0] visited_reg, visited_next;
    logic [NODE_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]     sum_reg, sum_next;
    logic                 rd_vld_reg;
    logic [NODE_W-1:0]    rd_col_reg;
    logic                 found_reg, found_next;
    logic [DIST_BITS-1:0] best_reg, best_next;
    logic [NODE_W-1:0]    best_node_reg, best_node_next;

    logic                 out_valid_reg;
    logic [NODE_W_OUT-1:0] node_reg;
    logic [LEN_W-1:0]     len_reg;
    logic                 last_reg;

    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [47:0]          dist_ext;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 take;
    logic [DIST_BITS-1:0] addend;
    logic [SUM_W-1:0]     sum_wide;
    logic [LEN_W-1:0]     sum_sat;
    logic [31:0]          best_ext;
    logic [CNT_W-1:0]     max_cnt;

    assign max_cnt = CNT_W'(MAX_NODES);

    // Clamp node count to the supported range; output register free to load
    always_comb
    begin
        status.out_free = !out_valid_reg || out_ready;
        if (ncount_reg < NODE_COUNT_MIN)
            status.n_eff = NODE_COUNT_MIN;
        else if (ncount_reg > max_cnt)
            status.n_eff = max_cnt;
        else
            status.n_eff = ncount_reg;
    end

    // Write side: entries outside the store are dropped
    assign wr_en    = cmd.mem_wr && ({1'b0, row} < max_cnt) && ({1'b0, col} < max_cnt);
    assign wr_addr  = ADDR_W'(row) * ADDR_W'(MAX_NODES) + ADDR_W'(col);
    assign dist_ext = 48'(dist_req);

    // Read side: scan of current row, or row 0 for the return edge
    assign rd_en   = cmd.rd_scan || cmd.rd_close;
    assign rd_addr = cmd.rd_close ? ADDR_W'(cur_reg)
                                  : ADDR_W'(cur_reg) * ADDR_W'(MAX_NODES) + ADDR_W'(cmd.col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= dist_ext[DIST_BITS-1:0];
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Min search; <= lets the highest index win a tie
    assign take = rd_vld_reg && !visited_reg[rd_col_reg]
                  && (!found_reg || (rd_data_reg <= best_reg));

    // Saturating length add
    assign addend   = cmd.emit_last ? rd_data_reg : best_reg;
    assign sum_wide = SUM_W'(sum_reg) + SUM_W'(addend);
    assign sum_sat  = (sum_wide > SUM_W'(LEN_MAX)) ? LEN_MAX : sum_wide[LEN_W-1:0];

    assign best_ext = 32'(best_node_reg);

    // Tour state next values
    always_comb
    begin
        visited_next   = visited_reg;
        cur_next       = cur_reg;
        sum_next       = sum_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        best_node_next = best_node_reg;
        if (take)
        begin
            found_next     = 1'b1;
            best_next      = rd_data_reg;
            best_node_next = rd_col_reg;
        end
        if (cmd.tour_init)
        begin
            visited_next = MAX_NODES'(1);
            cur_next     = '0;
            sum_next     = '0;
            found_next   = 1'b0;
        end
        else if (cmd.step)
        begin
            visited_next = visited_reg | (MAX_NODES'(1) << best_node_reg);
            cur_next     = best_node_reg;
            sum_next     = sum_sat;
            found_next   = 1'b0;
        end
        else if (cmd.emit_last)
        begin
            sum_next = sum_sat;
        end
    end

    // Control and tour state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncount_reg    <= NODE_COUNT_RST;
            visited_reg   <= '0;
            cur_reg       <= '0;
            sum_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                ncount_reg <= node_count;
            visited_reg <= visited_next;
            cur_reg     <= cur_next;
            sum_reg     <= sum_next;
            rd_vld_reg  <= cmd.rd_scan;
            found_reg   <= found_next;
            if (cmd.tour_init || cmd.step || cmd.emit_last)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_col_reg    <= cmd.col[NODE_W-1:0];
        best_reg      <= best_next;
        best_node_reg <= best_node_next;
        if (cmd.tour_init)
        begin
            node_reg <= '0;
            len_reg  <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.step)
        begin
            node_reg <= best_ext[NODE_W_OUT-1:0];
            len_reg  <= '0;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_last)
        begin
            node_reg <= '0;
            len_reg  <= sum_sat;
            last_reg <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign node        = node_reg;
    assign tour_length = len_reg;
    assign is_last     = last_reg;

endmodule

// ===== rtl/nearest_neighbor_tour.sv =====
// Matrix load takes one word per cycle while idle; the tour build starts on the word marked last.
// Tour of n nodes: each of the n-1 steps scans one row of the distance memory,
// n reads at one per cycle.
// Results: node 0 (from ST_START, once the output is free), one per step, then the length word.
// Reset clears control, tour state and sets node_count to 32; the matrix is not cleared.
// Nearest-neighbor tour top level: controller plus datapath
module nearest_neighbor_tour #(
    parameter int MAX_NODES = 32,
    parameter int DIST_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [nnt_pkg::CNT_W-1:0]      node_count,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [nnt_pkg::ROW_W-1:0]      row,
    input  logic [nnt_pkg::ROW_W-1:0]      col,
    input  logic [nnt_pkg::REQ_W-1:0]      dist_req,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nnt_pkg::NODE_W_OUT-1:0] node,
    output logic [nnt_pkg::LEN_W-1:0]      tour_length,
    output logic                           is_last
);
    import nnt_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Config register always writable
    assign cfg_ready = 1'b1;

    nnt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last     (last),
        .status   (status),
        .cmd      (cmd)
    );

    nnt_datapath #(
        .MAX_NODES (MAX_NODES),
        .DIST_BITS (DIST_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .node_count  (node_count),
        .row         (row),
        .col         (col),
        .dist_req    (dist_req),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node        (node),
        .tour_length (tour_length),
        .is_last     (is_last)
    );

endmodule

// ===== rtl/nnt_checker.sv =====
// Port-level checks for the nearest-neighbor tour, bound to the top level
`include "nearest_neighbor_tour_defines.svh"

module nnt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [nnt_pkg::NODE_W_OUT-1:0] node,
    input logic [nnt_pkg::LEN_W-1:0]      tour_length,
    input logic                           is_last
);

    // stalled result word holds
    `NNT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(node) && $stable(tour_length) && $stable(is_last))

    // length only travels with the final word
    `NNT_ASSERT_IMP(a_len_zero, out_valid && !is_last, tour_length == '0)

    // tour closes at node 0
    `NNT_ASSERT_IMP(a_close_node, out_valid && is_last, node == '0)

    // no loading while a tour is still in progress
    `NNT_ASSERT_IMP(a_no_load, out_valid && !is_last, !in_ready)

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node        (node),
    .tour_length (tour_length),
    .is_last     (is_last)
);

// ===== test/nearest_neighbor_tour_test.sv =====
// Testbench for the nearest-neighbor tour block: matrix load, tour prediction, result check
`timescale 1ns / 100ps

module nearest_neighbor_tour_test;
    import nnt_pkg::*;

    localparam int MAX_NODES     = 32;
    localparam int DIST_BITS     = 16;
    localparam int RANDOM_WORDS  = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1_500_000;

    typedef enum logic { STEP_CONFIG, STEP_WORD } step_kind_t;

    // One row of the directed script, or one random word
    typedef struct {
        step_kind_t       kind;
        logic [CNT_W-1:0] count;
        logic [ROW_W-1:0] src;
        logic [ROW_W-1:0] dst;
        logic [REQ_W-1:0] span;
        logic             closes;
        bit               typed;
        logic [LEN_W-1:0] typed_len;
    } script_row_t;

    // One tour position as it leaves the block
    typedef struct packed {
        logic [NODE_W_OUT-1:0] node;
        logic [LEN_W-1:0]      len;
        logic                  fin;
    } tour_stop_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      node_count;
    logic                  in_valid;
    logic                  in_ready;
    logic [ROW_W-1:0]      row;
    logic [ROW_W-1:0]      col;
    logic [REQ_W-1:0]      dist_req;
    logic                  last;
    logic                  out_valid;
    logic                  out_ready;
    logic [NODE_W_OUT-1:0] node;
    logic [LEN_W-1:0]      tour_length;
    logic                  is_last;

    // Predictor state
    logic [REQ_W-1:0] dist_mem [MAX_NODES][MAX_NODES];
    logic [31:0]      seen_mask;
    logic [4:0]       here_node;
    logic [LEN_W-1:0] path_len;
    logic [CNT_W-1:0] count_reg;

    tour_stop_t pending_stops[$];
    int         mismatches;
    int         cycles;
    bit         calm;

    // Directed script: typed lengths only on two-node tours
    script_row_t script [24] = '{
        '{STEP_CONFIG, 6'd2,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd1,  16'd65535, 1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd1,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd1,  5'd1,  16'd65535, 1'b1, 1'b1, 22'd131070},
        '{STEP_CONFIG, 6'd0,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd1,  16'd7,     1'b1, 1'b1, 22'd14},
        '{STEP_CONFIG, 6'd1,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd1,  16'd0,     1'b1, 1'b1, 22'd0},
        '{STEP_CONFIG, 6'd63, 5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd31, 5'd31, 16'h5555,  1'b1, 1'b0, 22'd0},
        '{STEP_CONFIG, 6'd33, 5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd31, 5'd0,  16'hAAAA,  1'b1, 1'b0, 22'd0},
        '{STEP_CONFIG, 6'd32, 5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd31, 16'd65535, 1'b1, 1'b0, 22'd0},
        '{STEP_CONFIG, 6'd4,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd1,  16'd5,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd2,  16'd5,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd0,  5'd3,  16'd5,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd3,  5'd1,  16'd5,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd3,  5'd2,  16'd5,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd2,  5'd1,  16'd5,     1'b1, 1'b0, 22'd0},
        '{STEP_CONFIG, 6'd3,  5'd0,  5'd0,  16'd0,     1'b0, 1'b0, 22'd0},
        '{STEP_WORD,   6'd0,  5'd20, 5'd9,  16'd1234,  1'b1, 1'b0, 22'd0}
    };

    nearest_neighbor_tour #(
        .MAX_NODES (MAX_NODES),
        .DIST_BITS (DIST_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .node_count  (node_count),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row         (row),
        .col         (col),
        .dist_req    (dist_req),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .node        (node),
        .tour_length (tour_length),
        .is_last     (is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small values make ties common
    function automatic logic [REQ_W-1:0] pick_dist();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return REQ_W'($urandom_range(0, 3));
        if (r == 4)
            return '0;
        if (r == 5)
            return '1;
        return REQ_W'($urandom_range(0, 65535));
    endfunction

    // Register value as the block uses it
    function automatic int clamp_count(input logic [CNT_W-1:0] v);
        if (v < 2)
            return 2;
        if (v > MAX_NODES)
            return MAX_NODES;
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [REQ_W-1:0] b);
        logic [LEN_W:0] s;
        s = a + b;
        return (s > LEN_MAX) ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // Store the word; on a closing word build the greedy tour and queue its stops
    task automatic absorb_word(input script_row_t w);
        tour_stop_t       stops[$];
        tour_stop_t       stop;
        int               n;
        int               j;
        int               k;
        logic [REQ_W-1:0] best;
        logic [REQ_W-1:0] v;
        logic [4:0]       best_j;
        bit               found;
        dist_mem[w.src][w.dst] = w.span;
        if (!w.closes)
            return;
        n = clamp_count(count_reg);
        seen_mask = 32'd1;
        here_node = '0;
        path_len  = '0;
        stop  = '{5'd0, '0, 1'b0};
        stops = {stops, stop};
        for (k = 1; k < n; k++)
        begin
            found  = 1'b0;
            best   = '0;
            best_j = '0;
            // ties go to the highest index
            for (j = 0; j < n; j++)
            begin
                if (seen_mask[j])
                    continue;
                v = dist_mem[here_node][j];
                if (!found || v <= best)
                begin
                    best   = v;
                    best_j = j[4:0];
                    found  = 1'b1;
                end
            end
            seen_mask[best_j] = 1'b1;
            path_len  = sat_add(path_len, best);
            here_node = best_j;
            stop  = '{best_j, '0, 1'b0};
            stops = {stops, stop};
        end
        // closing edge comes from row 0
        path_len = sat_add(path_len, dist_mem[0][here_node]);
        stop  = '{5'd0, path_len, 1'b1};
        stops = {stops, stop};
        if (w.typed)
        begin
            stops.delete();
            stop  = '{5'd0, '0, 1'b0};
            stops = {stops, stop};
            stop  = '{5'd1, '0, 1'b0};
            stops = {stops, stop};
            stop  = '{5'd0, w.typed_len, 1'b1};
            stops = {stops, stop};
        end
        pending_stops = {pending_stops, stops};
    endtask

    // Offer one matrix word, hold it until taken
    task automatic send_word(input script_row_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        row      <= w.src;
        col      <= w.dst;
        dist_req <= w.span;
        last     <= w.closes;
        do @(posedge clk); while (!in_ready);
        absorb_word(w);
    endtask

    // Quiet the input and let the block drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_stops.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_node_count(input logic [CNT_W-1:0] v);
        wait_idle();
        cfg_valid  <= 1'b1;
        node_count <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        count_reg = v;
    endtask

    task automatic check_stop();
        tour_stop_t want;
        tour_stop_t got;
        got = '{node, tour_length, is_last};
        if (pending_stops.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected result: node %0d length %0d last %0b",
                         node, tour_length, is_last);
            mismatches++;
        end
        else
        begin
            want = pending_stops.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                    $display("mismatch: node exp %0d got %0d, length exp %0d got %0d, last exp %0b got %0b",
                             want.node, got.node, want.len, got.len, want.fin, got.fin);
                mismatches++;
            end
        end
    endtask

    // Result side: accept, compare, stall at random
    initial
    begin : result_side
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_stop();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    // Run limit
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        script_row_t w;
        int          n;
        int          words_sent;
        int          burst;
        int          r;
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        node_count <= '0;
        in_valid   <= 1'b0;
        row        <= '0;
        col        <= '0;
        dist_req   <= '0;
        last       <= 1'b0;
        mismatches = 0;
        calm       = 1'b0;
        count_reg  = NODE_COUNT_RST;
        seen_mask  = '0;
        here_node  = '0;
        path_len   = '0;
        w = '{STEP_WORD, '0, '0, '0, '0, 1'b0, 1'b0, '0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the whole store at the reset node count; the final word builds a full tour
        for (int s = 0; s < MAX_NODES; s++)
            for (int d = 0; d < MAX_NODES; d++)
            begin
                w.src    = ROW_W'(s);
                w.dst    = ROW_W'(d);
                w.span   = pick_dist();
                w.closes = (s == MAX_NODES - 1) && (d == MAX_NODES - 1);
                send_word(w);
            end

        // Directed script
        foreach (script[i])
        begin
            if (script[i].kind == STEP_CONFIG)
                set_node_count(script[i].count);
            else
                send_word(script[i]);
        end

        // Random phases: new node count, then a burst of words
        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 6)
                set_node_count(CNT_W'($urandom_range(2, 6)));
            else if (r < 8)
                set_node_count(CNT_W'($urandom_range(7, 12)));
            else if (r == 8)
                set_node_count(CNT_W'($urandom_range(13, 32)));
            else
                set_node_count(CNT_W'($urandom_range(0, 63)));
            n = clamp_count(count_reg);
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    w.src = ROW_W'($urandom_range(0, 31));
                    w.dst = ROW_W'($urandom_range(0, 31));
                end
                else
                begin
                    w.src = ROW_W'($urandom_range(0, n - 1));
                    w.dst = ROW_W'($urandom_range(0, n - 1));
                end
                w.span   = pick_dist();
                w.closes = (i == burst - 1) || ($urandom_range(0, 5) == 0);
                send_word(w);
                words_sent++;
            end
        end

        calm = 1'b0;
        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_stops.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
